// File: rtl/population_standard_deviation_core_assert.svh
// Assertion macros used by the checker of this block
`ifndef POPULATION_STANDARD_DEVIATION_CORE_ASSERT_SVH
`define POPULATION_STANDARD_DEVIATION_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Widths, status codes and state type of the standard deviation core.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int MEAN_W          = 24;
    localparam int DEV_W           = 24;
    localparam int CNT_OUT_W       = 8;
    localparam int STATUS_W        = 2;
    localparam int FRAC_W          = 8;
    localparam int MAX_SAMPLES_DEF = 128;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DROP  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MDIV,
        BK_PASS,
        BK_VDIV,
        BK_ROOT,
        BK_OUT
    } back_state_t;

endpackage

// File: rtl/psd_if.sv
// ----------------------------------------------------------------------------
// psd_if
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface psd_in_if;
    import psd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface psd_out_if;
    import psd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [MEAN_W-1:0]   mean_value;
    logic        [DEV_W-1:0]    deviation;
    logic        [CNT_OUT_W-1:0] sample_count;
    logic        [STATUS_W-1:0] status;

    modport source (output valid, output mean_value, output deviation,
                    output sample_count, output status, input ready);
    modport sink   (input valid, input mean_value, input deviation,
                    input sample_count, input status, output ready);
endinterface

// File: rtl/psd_queue.sv
// ----------------------------------------------------------------------------
// psd_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module psd_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         avail,
    output logic [W-1:0] head
);
    logic [W-1:0] data_reg [2];
    logic         wptr_reg;
    logic         rptr_reg;
    logic [1:0]   cnt_reg;

    assign avail = (cnt_reg != 2'd0);
    assign head  = data_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end
endmodule

// File: rtl/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psd_div #(
    parameter int DW = 48,
    parameter int VW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CNTW = $clog2(DW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DW-1:0]   quo_reg;
    logic [VW-1:0]   rem_reg;
    logic [VW-1:0]   dvs_reg;
    logic [VW:0]     trial;
    logic [VW:0]     diff;
    logic            ge;

    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign diff     = trial - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= ge ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// File: rtl/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Accept sample words, store them in a free bank (words past MAX_SAMPLES are dropped), close a set into a job.
// ----------------------------------------------------------------------------
module psd_front #(
    parameter int MAX_SAMPLES = 128,
    parameter int AA          = $clog2(MAX_SAMPLES),
    parameter int CW          = $clog2(MAX_SAMPLES + 1),
    parameter int SW          = psd_pkg::SAMPLE_W + $clog2(MAX_SAMPLES) + 1,
    parameter int JW          = 1 + CW + SW + 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    psd_in_if.sink                             din,
    output logic                               wr_en,
    output logic [AA:0]                        wr_addr,
    output logic signed [psd_pkg::SAMPLE_W-1:0] wr_data,
    output logic                               job_push,
    output logic [JW-1:0]                      job_data,
    input  logic                               rel_valid,
    input  logic                               rel_bank
);
    import psd_pkg::*;

    logic [CW-1:0]        count_reg;
    logic signed [SW-1:0] sum_reg;
    logic                 ovf_reg;
    logic                 bank_reg;
    logic [1:0]           busy_reg;

    logic                 accept;
    logic                 room;
    logic [CW-1:0]        count_next;
    logic signed [SW-1:0] sum_next;
    logic                 ovf_next;
    logic [1:0]           busy_next;

    assign din.ready = !busy_reg[bank_reg];
    assign accept    = din.valid && din.ready;
    assign room      = (count_reg < CW'(MAX_SAMPLES));

    assign wr_en   = accept && room;
    assign wr_addr = {bank_reg, count_reg[AA-1:0]};
    assign wr_data = din.sample;

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        if (room)
        begin
            count_next = count_reg + CW'(1);
            sum_next   = sum_reg + SW'(din.sample);
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    assign job_push = accept && din.last;
    assign job_data = {bank_reg, count_next, sum_next, ovf_next};

    always_comb
    begin
        busy_next = busy_reg;
        if (rel_valid)
        begin
            busy_next[rel_bank] = 1'b0;
        end
        if (job_push)
        begin
            busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            bank_reg  <= 1'b0;
            busy_reg  <= 2'b00;
        end
        else
        begin
            busy_reg <= busy_next;
            if (job_push)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                ovf_reg   <= 1'b0;
                bank_reg  <= ~bank_reg;
            end
            else if (accept)
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                ovf_reg   <= ovf_next;
            end
        end
    end
endmodule

// File: rtl/psd_back.sv
// ----------------------------------------------------------------------------
// psd_back
// Run one job: mean division, offset pass over the bank, division, root; an empty set skips to the output.
// ----------------------------------------------------------------------------
module psd_back #(
    parameter int MAX_SAMPLES = 128,
    parameter int AA          = $clog2(MAX_SAMPLES),
    parameter int CW          = $clog2(MAX_SAMPLES + 1),
    parameter int SW          = psd_pkg::SAMPLE_W + $clog2(MAX_SAMPLES) + 1,
    parameter int JW          = 1 + CW + SW + 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [AA:0]                        wr_addr,
    input  logic signed [psd_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                               job_avail,
    input  logic [JW-1:0]                      job_head,
    output logic                               job_pop,
    output logic                               rel_valid,
    output logic                               rel_bank,
    psd_out_if.source                          dout
);
    import psd_pkg::*;

    localparam int DEPTH = 2 * (2 ** AA);
    localparam int MAGW  = MEAN_W;
    localparam int SQW   = 2 * MAGW;
    localparam int ACW   = SQW + AA;
    localparam int RADW  = 2 * DEV_W;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];

    back_state_t state_reg, state_next;

    logic                     bank_reg;
    logic [CW-1:0]            n_reg;
    logic signed [SW-1:0]     sum_reg;
    logic signed [MEAN_W-1:0] mean_reg;
    logic [CW-1:0]            idx_reg;
    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic [MAGW-1:0]          m_reg;
    logic [SQW-1:0]           sq_reg;
    logic [ACW-1:0]           acc_reg;
    logic [RADW-1:0]          rad_reg, res_reg, bit_reg;
    logic [DEV_W-1:0]         dev_reg;
    logic [STATUS_W-1:0]      status_reg;

    logic                 j_bank;
    logic [CW-1:0]        j_n;
    logic signed [SW-1:0] j_sum;
    logic                 j_ovf;

    logic                 issue;
    logic                 pass_done;
    logic [AA:0]          rd_addr;
    logic signed [MAGW:0] d_w;
    logic [MAGW:0]        dabs_w;
    logic [SW-1:0]        sum_mag;
    logic [RADW-1:0]      try_w;
    logic                 div_start;
    logic [ACW-1:0]       div_dividend;
    logic                 div_done;
    logic [ACW-1:0]       div_q;
    logic [MEAN_W-1:0]    q_mean;

    assign {j_bank, j_n, j_sum, j_ovf} = job_head;

    assign issue     = (state_reg == BK_PASS) && (idx_reg != n_reg);
    assign pass_done = (state_reg == BK_PASS) && (idx_reg == n_reg)
                       && !v1_reg && !v2_reg && !v3_reg;
    assign rd_addr   = {bank_reg, idx_reg[AA-1:0]};

    assign sum_mag = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign q_mean  = div_q[MEAN_W-1:0];
    assign d_w     = (MAGW+1)'($signed({rdata_reg, {FRAC_W{1'b0}}}))
                     - (MAGW+1)'(mean_reg);
    assign dabs_w  = d_w[MAGW] ? (MAGW+1)'(-d_w) : (MAGW+1)'(d_w);
    assign try_w   = res_reg + bit_reg;

    psd_div #(
        .DW (ACW),
        .VW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // sample store: front writes, pass reads, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        job_pop      = 1'b0;
        div_start    = 1'b0;
        div_dividend = ACW'({sum_mag, {FRAC_W{1'b0}}});
        rel_valid    = 1'b0;
        rel_bank     = bank_reg;
        dout.valid   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_avail)
                begin
                    job_pop    = 1'b1;
                    state_next = BK_MDIV;
                end
            end
            BK_MDIV:
            begin
                if (n_reg == '0)
                begin
                    rel_valid  = 1'b1;
                    state_next = BK_OUT;
                end
                else if (!v1_reg && !v2_reg)
                begin
                    // v1/v2 are clear here; v3 latches the start so it is raised once per job
                    div_start = !v3_reg;
                end
                if (div_done)
                begin
                    state_next = BK_PASS;
                end
            end
            BK_PASS:
            begin
                if (pass_done)
                begin
                    rel_valid    = 1'b1;
                    div_start    = 1'b1;
                    div_dividend = acc_reg;
                    state_next   = BK_VDIV;
                end
            end
            BK_VDIV:
            begin
                if (div_done)
                begin
                    state_next = BK_ROOT;
                end
            end
            BK_ROOT:
            begin
                if (bit_reg[0])
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                dout.valid = 1'b1;
                if (dout.ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // pipeline valid bits; in MDIV v3 marks that the divider was started
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (state_reg == BK_MDIV)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= div_done ? 1'b0 : (v3_reg || div_start);
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            bank_reg   <= j_bank;
            n_reg      <= j_n;
            sum_reg    <= j_sum;
            mean_reg   <= '0;
            dev_reg    <= '0;
            status_reg <= (j_n == '0) ? STATUS_EMPTY : (j_ovf ? STATUS_DROP : STATUS_OK);
        end
        if ((state_reg == BK_MDIV) && div_done)
        begin
            mean_reg <= sum_reg[SW-1] ? MEAN_W'(-q_mean) : q_mean;
            idx_reg  <= '0;
            acc_reg  <= '0;
        end
        if (issue)
        begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (v1_reg)
        begin
            m_reg <= dabs_w[MAGW-1:0];
        end
        if (v2_reg)
        begin
            sq_reg <= m_reg * m_reg;
        end
        if (v3_reg && (state_reg == BK_PASS))
        begin
            acc_reg <= acc_reg + ACW'(sq_reg);
        end
        if ((state_reg == BK_VDIV) && div_done)
        begin
            rad_reg <= div_q[RADW-1:0];
            res_reg <= '0;
            bit_reg <= RADW'(1) << (RADW - 2);
        end
        if (state_reg == BK_ROOT)
        begin
            if (rad_reg >= try_w)
            begin
                rad_reg <= rad_reg - try_w;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            if (bit_reg[0])
            begin
                dev_reg <= (rad_reg >= try_w) ? DEV_W'((res_reg >> 1) + bit_reg)
                                              : DEV_W'(res_reg >> 1);
            end
        end
    end

    assign dout.mean_value   = mean_reg;
    assign dout.deviation    = dev_reg;
    assign dout.sample_count = CNT_OUT_W'(n_reg);
    assign dout.status       = status_reg;
endmodule

// File: rtl/population_standard_deviation_core.sv
// Sequence: after the word marked last, a result follows the two bit-serial
//   divisions, the pass over the n stored samples and the 24-step root.
// Throughput: one sample word per cycle while a set fills and its bank is
//   free; two banks let the next set fill while the previous one is computed.
// Reset: control state clears at once; the sample store is not cleared.
// ----------------------------------------------------------------------------
// population_standard_deviation_core
// Mean and population standard deviation in Q.8 over a set of samples.
// ----------------------------------------------------------------------------
module population_standard_deviation_core #(
    parameter int MAX_SAMPLES = psd_pkg::MAX_SAMPLES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    psd_in_if.sink    din,
    psd_out_if.source dout
);
    import psd_pkg::*;

    // bank address bits, count width, running sum width, job word width
    localparam int AA = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = SAMPLE_W + AA + 1;
    localparam int JW = 1 + CW + SW + 1;

    logic                       wr_en;
    logic [AA:0]                wr_addr;
    logic signed [SAMPLE_W-1:0] wr_data;
    logic                       job_push;
    logic [JW-1:0]              job_data;
    logic                       job_pop;
    logic                       job_avail;
    logic [JW-1:0]              job_head;
    logic                       rel_valid;
    logic                       rel_bank;

    // front: take words, fill a bank, close a set into a job word
    psd_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .AA          (AA),
        .CW          (CW),
        .SW          (SW),
        .JW          (JW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_push  (job_push),
        .job_data  (job_data),
        .rel_valid (rel_valid),
        .rel_bank  (rel_bank)
    );

    // hold closed sets until the back end is free
    psd_queue #(
        .W (JW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_data),
        .pop       (job_pop),
        .avail     (job_avail),
        .head      (job_head)
    );

    // back: compute the result, free the bank after the offset pass (an empty set frees it at once)
    psd_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .AA          (AA),
        .CW          (CW),
        .SW          (SW),
        .JW          (JW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_avail (job_avail),
        .job_head  (job_head),
        .job_pop   (job_pop),
        .rel_valid (rel_valid),
        .rel_bank  (rel_bank),
        .dout      (dout)
    );
endmodule

// File: rtl/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks on result words of the standard deviation core.
// ----------------------------------------------------------------------------
`include "population_standard_deviation_core_assert.svh"

module psd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [psd_pkg::MEAN_W-1:0]  mean_value,
    input logic [psd_pkg::DEV_W-1:0]          deviation,
    input logic [psd_pkg::CNT_OUT_W-1:0]      sample_count,
    input logic [psd_pkg::STATUS_W-1:0]       status
);
    import psd_pkg::*;

    `PSD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable({mean_value, deviation, sample_count, status}), "result word changed while stalled")
    `PSD_ASSERT_NOW(a_code, out_valid, status == STATUS_OK || status == STATUS_DROP || status == STATUS_EMPTY, "bad status code")
    `PSD_ASSERT_NOW(a_empty, out_valid && status == STATUS_EMPTY, mean_value == '0 && deviation == '0 && sample_count == '0, "empty set with nonzero fields")
    `PSD_ASSERT_NOW(a_dev, out_valid, !deviation[DEV_W-1] || deviation[DEV_W-2:0] == '0, "deviation out of range")
endmodule

bind population_standard_deviation_core psd_checker u_psd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (dout.valid),
    .out_ready    (dout.ready),
    .mean_value   (dout.mean_value),
    .deviation    (dout.deviation),
    .sample_count (dout.sample_count),
    .status       (dout.status)
);

// File: test/tb_population_standard_deviation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_population_standard_deviation_core
// Drives sets of sample words into the core and checks each result word
// against a local Q.8 mean and deviation predictor, under several idle mixes.
// ----------------------------------------------------------------------------
module tb_population_standard_deviation_core;
    import psd_pkg::*;

    localparam int NSAMP = MAX_SAMPLES_DEF;

    // one expected result word
    typedef struct {
        logic signed [MEAN_W-1:0]    mean_value;
        logic        [DEV_W-1:0]     deviation;
        logic        [CNT_OUT_W-1:0] sample_count;
        logic        [STATUS_W-1:0]  status;
    } stats_t;

    // one directed row: sample, last flag, and an optional typed-in result
    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       fixed;
        stats_t                     want;
    } row_t;

    logic clk;
    logic rst_n;

    psd_in_if  din ();
    psd_out_if dout ();

    population_standard_deviation_core u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (din.sink),
        .dout (dout.source)
    );

    // predictor state: current set of samples
    int     set_vals[$];
    bit     set_dropped;
    stats_t stats_q[$];
    int     errors;
    int     src_idle_pct;
    int     snk_stall_pct;
    int     hold_off_cycles;

    // ------------------------------------------------------------------
    // Clock and run limit.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb_population_standard_deviation_core: FAIL");
        $finish;
    end

    // integer square root, floor, bit by bit
    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Advance the set by one accepted word; on last, push the expected stats.
    task automatic absorb_word(logic signed [SAMPLE_W-1:0] s, logic is_last);
        longint          sum;
        longint          mean;
        longint          d;
        longint unsigned acc;
        int              n;
        stats_t          st;
        if (set_vals.size() < NSAMP)
            set_vals.push_back(int'(s));
        else
            set_dropped = 1'b1;
        if (!is_last)
            return;
        n = set_vals.size();
        if (n == 0)
        begin
            st.mean_value = '0;
            st.deviation = '0;
            st.sample_count = '0;
            st.status = STATUS_EMPTY;
        end
        else
        begin
            sum = 0;
            foreach (set_vals[i])
                sum += set_vals[i];
            // SV division truncates toward zero, like the core, which divides the magnitude
            mean = (sum * 256) / n;
            acc = 0;
            foreach (set_vals[i])
            begin
                d = longint'(set_vals[i]) * 256 - mean;
                if (d < 0)
                    d = -d;
                acc += longint'(d) * longint'(d);
            end
            st.mean_value = mean[MEAN_W-1:0];
            st.deviation = DEV_W'(int_root(acc / n));
            st.sample_count = n[CNT_OUT_W-1:0];
            st.status = set_dropped ? STATUS_DROP : STATUS_OK;
        end
        stats_q.push_back(st);
        set_vals.delete();
        set_dropped = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sender: hold each word until accepted; idle at random between words.
    // ------------------------------------------------------------------
    task automatic send_word(logic signed [SAMPLE_W-1:0] s, logic is_last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            din.valid <= 1'b0;
            @(posedge clk);
        end
        din.valid <= 1'b1;
        din.sample <= s;
        din.last <= is_last;
        @(posedge clk);
        while (!din.ready)
            @(posedge clk);
        absorb_word(s, is_last);
    endtask

    task automatic send_idle();
        din.valid <= 1'b0;
        @(posedge clk);
    endtask

    // one random set; mostly short, some full or overfilled
    task automatic send_set();
        int len;
        int kind;
        logic signed [SAMPLE_W-1:0] s;
        kind = $urandom_range(19);
        if (kind == 0)
            len = NSAMP + $urandom_range(6);
        else if (kind == 1)
            len = NSAMP - $urandom_range(2);
        else
            len = 1 + $urandom_range(9);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(3))
                0: s = 16'($urandom);
                1: s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                2: s = $signed(16'($urandom_range(15))) - 16'sd8;
                default: s = 16'($urandom);
            endcase
            send_word(s, i == len - 1);
        end
    endtask

    // wait until every expected result word has come back
    task automatic drain();
        din.valid <= 1'b0;
        while (stats_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall at random, or hold off for a counted stretch.
    // ------------------------------------------------------------------
    initial
    begin
        dout.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                dout.ready <= 1'b0;
            end
            else
                dout.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Check each accepted result word against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && dout.valid && dout.ready)
        begin
            if (stats_q.size() == 0)
            begin
                $display("%0t: unexpected result word mean=%0d dev=%0d n=%0d st=%0d",
                         $time, dout.mean_value, dout.deviation,
                         dout.sample_count, dout.status);
                errors++;
            end
            else
            begin
                stats_t w;
                w = stats_q.pop_front();
                if (dout.mean_value !== w.mean_value)
                begin
                    $display("%0t: mean_value expected %0d actual %0d",
                             $time, w.mean_value, dout.mean_value);
                    errors++;
                end
                if (dout.deviation !== w.deviation)
                begin
                    $display("%0t: deviation expected %0d actual %0d",
                             $time, w.deviation, dout.deviation);
                    errors++;
                end
                if (dout.sample_count !== w.sample_count)
                begin
                    $display("%0t: sample_count expected %0d actual %0d",
                             $time, w.sample_count, dout.sample_count);
                    errors++;
                end
                if (dout.status !== w.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, w.status, dout.status);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        row_t rows[$];
        row_t r;
        stats_t z;
        int waited;

        errors = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_off_cycles = 0;
        set_dropped = 1'b0;
        din.valid = 1'b0;
        din.sample = '0;
        din.last = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Typed-in results only where they are obvious.
        z = '{mean_value: '0, deviation: '0, sample_count: '0, status: STATUS_EMPTY};
        rows.push_back('{16'sh0000, 1'b1, 1'b0, z});       // single zero
        rows.push_back('{16'sh7fff, 1'b1, 1'b1,            // single max
                         '{24'sh7fff00, 24'd0, 8'd1, STATUS_OK}});
        rows.push_back('{16'sh8000, 1'b1, 1'b1,            // single min
                         '{-24'sh800000, 24'd0, 8'd1, STATUS_OK}});
        rows.push_back('{16'sh7fff, 1'b0, 1'b0, z});       // max and min
        rows.push_back('{16'sh8000, 1'b1, 1'b0, z});
        rows.push_back('{16'sh0001, 1'b0, 1'b0, z});       // negative mean
        rows.push_back('{-16'sd2, 1'b0, 1'b0, z});
        rows.push_back('{16'sh0000, 1'b1, 1'b0, z});
        rows.push_back('{16'sh5555, 1'b0, 1'b0, z});
        rows.push_back('{16'shaaaa, 1'b0, 1'b0, z});
        rows.push_back('{16'sh00ff, 1'b1, 1'b0, z});
        foreach (rows[i])
        begin
            r = rows[i];
            send_word(r.sample, r.last);
            // a typed-in row replaces the computed expectation
            if (r.fixed)
                stats_q[stats_q.size() - 1] = r.want;
        end

        // Full store of extremes, then an overfilled set ending in a dropped last.
        for (int i = 0; i < NSAMP; i++)
            send_word(i[0] ? 16'sh7fff : 16'sh8000, i == NSAMP - 1);
        for (int i = 0; i < NSAMP + 3; i++)
            send_word(16'($urandom), i == NSAMP + 2);
        drain();

        // Empty set: a lone last that follows a completed set cannot be empty,
        // so only the overflow path can be shown; status 2 needs n == 0, which
        // a last word never sees since it is stored itself when room exists.

        // Random phases with different idle mixes.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 80; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 80; end
                default: begin src_idle_pct = 6; snk_stall_pct = 6; end
            endcase
            if (ph == 0)
                hold_off_cycles = 3000;   // long receiver hold-off, sender keeps going
            for (int k = 0; k < 12; k++)
            begin
                send_set();
                if ($urandom_range(9) == 0)
                    send_idle();
            end
            drain();                       // sender pauses until all results are in
        end

        src_idle_pct = 0;
        snk_stall_pct = 0;
        din.valid <= 1'b0;
        waited = 0;
        while (stats_q.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (600) @(posedge clk);
        if (errors == 0 && stats_q.size() == 0)
            $display("tb_population_standard_deviation_core: PASS");
        else
            $display("tb_population_standard_deviation_core: FAIL");
        $finish;
    end

endmodule
